// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- hw/rtl/arvm_pkg.sv -----
// ----------------------------------------------------------------------------
// arvm_pkg
// Shared types and constants of the adaptive rank value mapper.
// ----------------------------------------------------------------------------
package arvm_pkg;
  localparam int unsigned FieldW  = 10;
  localparam int unsigned MappedW = 18;
  localparam int unsigned FracW   = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_RANK_LIM  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_OUT_SCALE = 1'b1;
  localparam logic [FieldW-1:0]  FullScale = 10'd1023;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture sample, start of item
    logic clr_step;   // one step of the clearing pass
    logic scan_step;  // one step of the rank scan
    logic mark;       // write seen bit, bump count
    logic div_init;   // load divider
    logic div_step;   // one quotient bit
    logic out_load;   // capture result
  } arvm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clip;
    logic clr_done;
    logic scan_done;
    logic div_done;
  } arvm_sts_t;
endpackage

// ----- hw/rtl/arvm_stream_if.sv -----
// ----------------------------------------------------------------------------
// arvm_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface arvm_stream_if #(
  parameter int unsigned W = 10
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/arvm_ram.sv -----
// ----------------------------------------------------------------------------
// arvm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module arvm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/arvm_datapath.sv -----
// ----------------------------------------------------------------------------
// arvm_datapath
// Seen bitmap, rank scan counter, distinct count and restoring divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module arvm_datapath #(
  parameter int unsigned VALUE_RANGE = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  arvm_pkg::arvm_cmd_t                 cmd,
  output arvm_pkg::arvm_sts_t                 sts,
  input  logic [arvm_pkg::FieldW-1:0]         sample,
  input  logic [arvm_pkg::FieldW-1:0]         rank_lim,
  input  logic [arvm_pkg::FieldW-1:0]         out_scale,
  output logic [arvm_pkg::MappedW-1:0]        mapped,
  output logic                                newly_seen,
  output logic                                clipped
);
  localparam int unsigned AW  = $clog2(VALUE_RANGE);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned NW  = CW + arvm_pkg::FieldW + arvm_pkg::FracW;
  localparam int unsigned SCW = $clog2(NW + 1);

  logic [arvm_pkg::FieldW-1:0]  samp_r;
  logic [AW-1:0]                samp_a;     // sample as a bitmap address
  logic [AW:0]                  addr_r;     // sweep address, top bit ends it
  logic [CW-1:0]                below_r, count_r;
  logic                         first_r;    // first scan cycle, no read data yet
  logic                         seen_r;
  logic [NW-1:0]                num_r;
  logic [CW:0]                  rem_r;
  logic [SCW-1:0]               dcnt_r;
  logic [arvm_pkg::MappedW-1:0] mapped_r;
  logic                         newly_r, clip_r;
  logic                         rd;
  logic                         ram_we;
  logic [AW-1:0]                ram_addr;
  logic [CW:0]                  trial;
  logic [CW-1:0]                pos;
  logic [CW+arvm_pkg::FieldW-1:0] prod;

  assign samp_a = AW'(samp_r);

  // Clip: above rank_lim or beyond the bitmap.
  assign sts.clip = (samp_r > rank_lim) ||
                    ({{(32-arvm_pkg::FieldW){1'b0}}, samp_r} >= 32'(VALUE_RANGE));
  assign sts.clr_done  = addr_r[AW];
  // Scan reads entries 0..sample; the last read returns the sample's own bit.
  assign sts.scan_done = !first_r && (addr_r[AW-1:0] == samp_a + AW'(1));
  assign sts.div_done  = (dcnt_r == '0);

  assign ram_we   = cmd.clr_step || cmd.mark;
  assign ram_addr = cmd.mark ? samp_a : addr_r[AW-1:0];

  arvm_ram #(.WIDTH(1), .DEPTH(VALUE_RANGE)) u_seen (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.mark),
    .rdata (rd)
  );

  assign pos   = below_r + CW'(!seen_r);
  assign prod  = (CW+arvm_pkg::FieldW)'(pos) * (CW+arvm_pkg::FieldW)'(out_scale);
  assign trial = {rem_r[CW-1:0], num_r[NW-1]};

  // Sweep counter, rank count and divider registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      count_r <= '0;
      first_r <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      if (cmd.clr_step) addr_r <= addr_r + 1'b1;
      if (cmd.load) begin
        addr_r  <= '0;
        below_r <= '0;
        first_r <= 1'b1;
      end
      if (cmd.scan_step) begin
        addr_r  <= addr_r + 1'b1;
        first_r <= 1'b0;
        if (!first_r) begin
          if (addr_r[AW-1:0] == samp_a + AW'(1)) seen_r <= rd;
          else below_r <= below_r + CW'(rd);
        end
      end
      if (cmd.mark && !seen_r) count_r <= count_r + 1'b1;
      if (cmd.div_init) begin
        num_r  <= NW'({prod, {arvm_pkg::FracW{1'b0}}});
        rem_r  <= '0;
        dcnt_r <= SCW'(NW);
      end
      if (cmd.div_step) begin
        if (trial >= {1'b0, count_r}) begin
          rem_r <= trial - {1'b0, count_r};
          num_r <= {num_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          num_r <= {num_r[NW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) samp_r <= sample;
    if (cmd.out_load) begin
      if (sts.clip) begin
        mapped_r <= arvm_pkg::MappedW'({out_scale, {arvm_pkg::FracW{1'b0}}});
        newly_r  <= 1'b0;
        clip_r   <= 1'b1;
      end else begin
        mapped_r <= num_r[arvm_pkg::MappedW-1:0];
        newly_r  <= !seen_r;
        clip_r   <= 1'b0;
      end
    end
  end

  assign mapped     = mapped_r;
  assign newly_seen = newly_r;
  assign clipped    = clip_r;

  `ASSERT_IMPLIES(a_div_nonzero, clk, rst_n, cmd.div_step, count_r != '0)
  `ASSERT_IMPLIES(a_pos_le_count, clk, rst_n, cmd.div_init, pos <= count_r + CW'(!seen_r))
  `ASSERT_NEXT(a_mark_bumps, clk, rst_n, cmd.mark && !seen_r, count_r == $past(count_r) + 1'b1)
endmodule

// ----- hw/rtl/arvm_ctrl.sv -----
// ----------------------------------------------------------------------------
// arvm_ctrl
// Sequencer: clearing pass, rank scan, mark, divide, result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module arvm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output arvm_pkg::arvm_cmd_t cmd,
  input  arvm_pkg::arvm_sts_t sts
);
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_MARK  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  // Output register frees when taken; a new item may run meanwhile.
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          cmd.clr_step = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = sts.clip ? S_DONE : S_SCAN;
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_done) cmd.div_step = 1'b1;
        else state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    // Divider loads the cycle the count is bumped.
    cmd.div_init = (state_r == S_MARK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  `ASSERT_IMPLIES(a_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `ASSERT_IMPLIES(a_no_drop, clk, rst_n, cmd.out_load, !ovalid_r || out_ready)
  `ASSERT_NEXT(a_load_check, clk, rst_n, cmd.load, state_r == S_CHECK)
endmodule

// ----- hw/rtl/adaptive_rank_value_mapper.sv -----
// ----------------------------------------------------------------------------
// adaptive_rank_value_mapper
// Ranks samples among distinct values seen and scales rank to full scale.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_      in   sample[9:0]
//  out_     out  mapped[17:0], newly_seen, clipped
//  cfg_     in   index[0], data[9:0] (0 rank limit, 1 output full scale)
//
//  After reset a clearing pass zeroes the bitmap; no sample is taken
//  meanwhile. A ranked sample passes through accept, check, scan cycles (one
//  bitmap read each), mark, divider cycles (one quotient bit each) and a
//  final done check, then the result load. A clipped sample passes through
//  accept, check and the result load.
//  The result register holds while out_ready is low; the next item may run.
// ----------------------------------------------------------------------------
module adaptive_rank_value_mapper #(
  parameter int unsigned VALUE_RANGE = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  arvm_stream_if.sink         in_ch,
  arvm_stream_if.source       out_ch,
  arvm_stream_if.sink         cfg_ch
);
  arvm_pkg::arvm_cmd_t          cmd;
  arvm_pkg::arvm_sts_t          sts;
  logic [arvm_pkg::FieldW-1:0]  rank_lim_r, out_scale_r;
  logic [arvm_pkg::MappedW-1:0] mapped;
  logic                         newly_seen, clipped;

  // Configuration registers; always ready.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_lim_r  <= arvm_pkg::FullScale;
      out_scale_r <= arvm_pkg::FullScale;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data[arvm_pkg::FieldW])
        arvm_pkg::CFG_RANK_LIM:  rank_lim_r  <= cfg_ch.data[arvm_pkg::FieldW-1:0];
        arvm_pkg::CFG_OUT_SCALE: out_scale_r <= cfg_ch.data[arvm_pkg::FieldW-1:0];
        default: ;
      endcase
    end
  end

  arvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  arvm_datapath #(.VALUE_RANGE(VALUE_RANGE)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .sample     (in_ch.data),
    .rank_lim   (rank_lim_r),
    .out_scale  (out_scale_r),
    .mapped     (mapped),
    .newly_seen (newly_seen),
    .clipped    (clipped)
  );

  assign out_ch.data = {mapped, newly_seen, clipped};
endmodule

// ----- test/arvm_rank_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arvm_rank_checker
// Watches the sample, result and register channels of the rank mapper,
// tracks the seen-value bitmap on its own, and compares every result transfer
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module arvm_rank_checker #(
  parameter int unsigned VALUE_RANGE = 1024
) (
  input  logic   clk,
  input  logic   rst_n,
  arvm_stream_if in_mon,
  arvm_stream_if out_mon,
  arvm_stream_if cfg_mon,
  output int     fail_count,
  output int     pending
);

  typedef struct packed {
    logic [arvm_pkg::MappedW-1:0] mapped;
    logic                         newly_seen;
    logic                         clipped;
  } rank_result_t;

  // Tracked block state
  logic [arvm_pkg::FieldW-1:0] lim_in;
  logic [arvm_pkg::FieldW-1:0] full_out;
  logic                        seen [VALUE_RANGE];
  int unsigned                 seen_total;
  rank_result_t                pending_results [$];

  // Print one mismatch line and count it
  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Rank the sample among seen values and scale it to full_out
  function automatic rank_result_t rank_scale(input logic [arvm_pkg::FieldW-1:0] s);
    rank_result_t r;
    int unsigned  below;
    logic [63:0]  num;
    below = 0;
    r     = '0;
    if (s > lim_in || s >= VALUE_RANGE) begin
      r.mapped  = arvm_pkg::MappedW'({full_out, arvm_pkg::FracW'(0)});
      r.clipped = 1'b1;
      return r;
    end
    for (int unsigned i = 0; i < s; i++) if (seen[i]) below++;
    if (!seen[s]) begin
      seen[s] = 1'b1;
      seen_total++;
      below++;
      r.newly_seen = 1'b1;
    end
    num      = (64'(below) * 64'(full_out)) << arvm_pkg::FracW;
    r.mapped = arvm_pkg::MappedW'(num / 64'(seen_total));
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    lim_in     = arvm_pkg::FullScale;
    full_out   = arvm_pkg::FullScale;
    seen_total = 0;
    foreach (seen[i]) seen[i] = 1'b0;
  end

  // Observe transfers at the rising edge
  always @(posedge clk) begin
    rank_result_t got, want;
    if (rst_n) begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.data[arvm_pkg::FieldW] == arvm_pkg::CFG_RANK_LIM)
          lim_in = cfg_mon.data[arvm_pkg::FieldW-1:0];
        else full_out = cfg_mon.data[arvm_pkg::FieldW-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (pending_results.size() == 0) begin
          report("unexpected result", got.mapped, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.mapped !== want.mapped) report("mapped", got.mapped, want.mapped);
          if (got.newly_seen !== want.newly_seen)
            report("newly_seen", got.newly_seen, want.newly_seen);
          if (got.clipped !== want.clipped) report("clipped", got.clipped, want.clipped);
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(rank_scale(in_mon.data));
    end
    pending = pending_results.size();
  end

endmodule

// ----- test/tb_adaptive_rank_value_mapper.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_rank_value_mapper
// Drives directed and random samples through the rank mapper under several
// register settings and handshake idling patterns; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_adaptive_rank_value_mapper;

  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam longint unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned PHASE_ITEMS = 390;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic in_fire;
  logic cfg_fire;
  longint unsigned cycles;

  arvm_stream_if #(.W(arvm_pkg::FieldW))       in_ch ();
  arvm_stream_if #(.W(arvm_pkg::MappedW + 2))  out_ch ();
  arvm_stream_if #(.W(arvm_pkg::FieldW + 1))   cfg_ch ();

  adaptive_rank_value_mapper dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  arvm_rank_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_mon   (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Transfer flags, read back at the following falling edge
  always @(posedge clk) begin
    in_fire  <= in_ch.valid && in_ch.ready;
    cfg_fire <= cfg_ch.valid && cfg_ch.ready;
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Send one sample; called and returns at a falling edge
  task automatic send_sample(input logic [arvm_pkg::FieldW-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = s;
    do @(negedge clk); while (!in_fire);
    in_ch.valid = 1'b0;
  endtask

  // Write one register once the block has drained
  task automatic write_reg(input logic [arvm_pkg::CfgIdxW-1:0] idx,
                           input logic [arvm_pkg::FieldW-1:0] val);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = {idx, val};
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid = 1'b0;
  endtask

  // Mostly small samples to keep the rank scan short
  function automatic logic [arvm_pkg::FieldW-1:0] pick_sample(
    input logic [arvm_pkg::FieldW-1:0] lim
  );
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return arvm_pkg::FieldW'($urandom_range(0, 127));
    if (r < 85) return arvm_pkg::FieldW'($urandom);
    if (r < 95) return lim + arvm_pkg::FieldW'($urandom_range(0, 2)) - 1'b1;
    return arvm_pkg::FieldW'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [arvm_pkg::FieldW-1:0] lim;
    cycles        = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, repeats, alternating bits, clipping, zero scale
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    send_sample(10'd0);
    send_sample(10'd1);
    send_sample(10'd1022);
    send_sample(10'd1023);
    send_sample(10'h2AA);
    send_sample(10'h155);
    send_sample(10'h2AA);
    write_reg(arvm_pkg::CFG_RANK_LIM, 10'd100);
    send_sample(10'd101);
    send_sample(10'd100);
    send_sample(10'd1023);
    send_sample(10'd50);
    write_reg(arvm_pkg::CFG_OUT_SCALE, 10'd0);
    send_sample(10'd7);
    send_sample(10'd200);
    write_reg(arvm_pkg::CFG_RANK_LIM, 10'd0);
    send_sample(10'd0);
    send_sample(10'd1);
    write_reg(arvm_pkg::CFG_OUT_SCALE, 10'd1);
    send_sample(10'd0);
    send_sample(10'd5);

    // Random phases over several register settings and idling patterns
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(arvm_pkg::CFG_RANK_LIM, 10'd1023);
          write_reg(arvm_pkg::CFG_OUT_SCALE, 10'd1023);
        end
        1: begin
          write_reg(arvm_pkg::CFG_RANK_LIM, 10'd300);
          write_reg(arvm_pkg::CFG_OUT_SCALE, 10'd1);
        end
        2: begin
          write_reg(arvm_pkg::CFG_RANK_LIM, 10'd64);
          write_reg(arvm_pkg::CFG_OUT_SCALE, 10'd1023);
        end
        3: begin
          write_reg(arvm_pkg::CFG_RANK_LIM, arvm_pkg::FieldW'($urandom));
          write_reg(arvm_pkg::CFG_OUT_SCALE, arvm_pkg::FieldW'($urandom));
        end
        default: begin
          write_reg(arvm_pkg::CFG_RANK_LIM, 10'd1023);
          write_reg(arvm_pkg::CFG_OUT_SCALE, 10'h2AA);
        end
      endcase
      lim = (p == 1) ? 10'd300 : (p == 2) ? 10'd64 : 10'd1023;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i < PHASE_ITEMS / 3) begin
          send_idle_pct = 37;
          recv_idle_pct = 47;
        end else if (i < 2 * PHASE_ITEMS / 3) begin
          send_idle_pct = 47;
          recv_idle_pct = 37;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_sample(pick_sample(lim));
      end
    end

    // Drain and verdict
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/arvm_pkg.sv
hw/rtl/arvm_stream_if.sv
hw/rtl/arvm_ram.sv
hw/rtl/arvm_datapath.sv
hw/rtl/arvm_ctrl.sv
hw/rtl/adaptive_rank_value_mapper.sv
test/arvm_rank_checker.sv
test/tb_adaptive_rank_value_mapper.sv
